// File: rtl/mprs_pkg.sv
package mprs_pkg;

    // Marker geometry
    localparam int PAT_BYTES  = 5;
    localparam int WIN_CELLS  = PAT_BYTES - 1;
    localparam int PAT_WIDTH  = 8 * PAT_BYTES;
    localparam int LEN_WIDTH  = 32;

    // Register reset values
    localparam logic [PAT_WIDTH-1:0] BEGIN_RESET = 40'h685720F1B1;
    localparam logic [PAT_WIDTH-1:0] END_RESET   = 40'h68B1F12057;
    localparam logic [7:0]           SIZE_RESET  = 8'd10;

    // Configuration register indexes
    localparam logic [1:0] CFG_BEGIN = 2'd0;
    localparam logic [1:0] CFG_END   = 2'd1;
    localparam logic [1:0] CFG_SIZE  = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_REGION = 2'd0;
    localparam logic [1:0] KIND_NO_END = 2'd1;
    localparam logic [1:0] KIND_ORDER  = 2'd2;
    localparam logic [1:0] KIND_DONE   = 2'd3;

    typedef struct packed {
        logic [1:0]           kind;
        logic [LEN_WIDTH-1:0] start;
        logic [LEN_WIDTH-1:0] length;
        logic                 fin;
    } result_t;

    // Results produced by one accepted byte
    typedef struct packed {
        logic [1:0] count;
        result_t    r0;
        result_t    r1;
    } push_t;

    // Per-cell byte compare against both marker patterns
    typedef struct packed {
        logic hit_begin;
        logic hit_end;
    } match_t;

endpackage

// File: rtl/mprs_cell.sv
module mprs_cell
    import mprs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       shift_en,
    input  logic       clear,
    input  logic [7:0] byte_in,
    input  logic [7:0] begin_byte,
    input  logic [7:0] end_byte,
    output logic [7:0] byte_out,
    output match_t     match
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Take the neighbor's byte on a beat, drop to zero at stream end
    always_comb
    begin
        byte_next = byte_reg;
        if (shift_en)
        begin
            byte_next = clear ? 8'd0 : byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'd0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    // Compare the held byte against this cell's slice of each pattern
    assign byte_out        = byte_reg;
    assign match.hit_begin = (byte_reg == begin_byte);
    assign match.hit_end   = (byte_reg == end_byte);

endmodule

// File: rtl/mprs_ctrl.sv
module mprs_ctrl
    import mprs_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       accept,
    input  logic       last,
    input  match_t     full_match,
    input  logic [7:0] marker_size,
    output push_t      push
);

    localparam int OW = OFFSET_WIDTH;
    localparam int LW = (OW > LEN_WIDTH) ? OW : LEN_WIDTH;

    typedef enum logic [1:0] {
        SEEK_BEGIN,
        SEEK_END,
        HALTED
    } mode_t;

    mode_t         mode_reg,   mode_next;
    logic [OW-1:0] pos_reg,    pos_next;
    logic [OW-1:0] ss_reg,     ss_next;
    logic [OW-1:0] ob_reg,     ob_next;
    logic          stray_reg,  stray_next;

    logic          eligible;
    logic          hit_b;
    logic          hit_e;
    logic [OW-1:0] s_pos;
    logic [OW-1:0] ob_src;
    logic [OW:0]   start_sum;
    logic [LW-1:0] start_w;
    logic [LW-1:0] diff_w;
    logic          len_ok;
    logic          emit;
    result_t       region;
    result_t       term;
    mode_t         mode_mid;

    // Window position and eligibility
    assign eligible = (pos_reg >= ss_reg) && ((pos_reg - ss_reg) >= OW'(WIN_CELLS));
    assign hit_b    = eligible && full_match.hit_begin;
    assign hit_e    = eligible && full_match.hit_end;
    assign s_pos    = pos_reg - OW'(WIN_CELLS);

    // Region arithmetic; begin offset is this byte's when the pair lands at once
    assign ob_src    = (mode_reg == SEEK_BEGIN) ? s_pos : ob_reg;
    assign start_sum = {1'b0, ob_src} + (OW + 1)'(marker_size);
    assign start_w   = LW'(start_sum[OW-1:0]);
    assign diff_w    = LW'(s_pos) - LW'(ob_src) - LW'(marker_size);
    assign len_ok    = (s_pos < ob_src) || ({1'b0, s_pos} >= start_sum);

    always_comb
    begin
        region.kind   = KIND_REGION;
        region.start  = start_w[LEN_WIDTH-1:0];
        region.length = len_ok ? diff_w[LEN_WIDTH-1:0] : '0;
        region.fin    = 1'b0;
    end

    // Mode update for one byte
    always_comb
    begin
        mode_mid   = mode_reg;
        ss_next    = ss_reg;
        ob_next    = ob_reg;
        stray_next = stray_reg;
        pos_next   = pos_reg;
        emit       = 1'b0;
        case (mode_reg)
            SEEK_BEGIN:
            begin
                if (hit_b)
                begin
                    if (stray_reg)
                    begin
                        mode_mid = HALTED;
                    end
                    else
                    begin
                        ob_next = s_pos;
                        if (hit_e)
                        begin
                            emit = 1'b1;
                        end
                        else
                        begin
                            mode_mid = SEEK_END;
                        end
                    end
                end
                else if (hit_e)
                begin
                    stray_next = 1'b1;
                end
            end
            SEEK_END:
            begin
                if (hit_e)
                begin
                    emit = 1'b1;
                end
            end
            default:
            begin
                mode_mid = HALTED;
            end
        endcase
        if (emit)
        begin
            ss_next    = s_pos + OW'(marker_size);
            mode_mid   = SEEK_BEGIN;
            stray_next = 1'b0;
        end
        pos_next  = pos_reg + OW'(1);
        mode_next = mode_mid;
        if (last)
        begin
            mode_next  = SEEK_BEGIN;
            pos_next   = '0;
            ss_next    = '0;
            ob_next    = '0;
            stray_next = 1'b0;
        end
    end

    // Terminal result from the mode left by this byte
    always_comb
    begin
        term.start  = '0;
        term.length = '0;
        term.fin    = 1'b1;
        case (mode_mid)
            SEEK_BEGIN: term.kind = KIND_DONE;
            SEEK_END:   term.kind = KIND_NO_END;
            default:    term.kind = KIND_ORDER;
        endcase
    end

    // Region first, terminal result after it
    always_comb
    begin
        push.count = 2'd0;
        push.r0    = region;
        push.r1    = term;
        if (accept)
        begin
            if (emit && last)
            begin
                push.count = 2'd2;
            end
            else if (emit)
            begin
                push.count = 2'd1;
            end
            else if (last)
            begin
                push.count = 2'd1;
                push.r0    = term;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= SEEK_BEGIN;
            pos_reg   <= '0;
            ss_reg    <= '0;
            ob_reg    <= '0;
            stray_reg <= 1'b0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            ss_reg    <= ss_next;
            ob_reg    <= ob_next;
            stray_reg <= stray_next;
        end
    end

endmodule

// File: rtl/mprs_outq.sv
module mprs_outq
    import mprs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  push_t   push,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    result_t         q_reg [DEPTH];
    logic [AW-1:0]   wr_reg, wr_next;
    logic [AW-1:0]   rd_reg, rd_next;
    logic [AW:0]     cnt_reg, cnt_next;
    logic            pop;
    logic [AW-1:0]   wr_plus;

    // Keep space for the two results one byte may cause
    assign room      = (cnt_reg <= (AW + 1)'(DEPTH - 2));
    assign out_valid = (cnt_reg != '0);
    assign out_res   = q_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    assign wr_plus   = wr_reg + AW'(1);

    // Advance pointers and fill count
    always_comb
    begin
        wr_next  = wr_reg + AW'(push.count);
        rd_next  = pop ? rd_reg + AW'(1) : rd_reg;
        cnt_next = cnt_reg + (AW + 1)'(push.count) - (AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Store up to two results per cycle
    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            q_reg[wr_reg] <= push.r0;
        end
        if (push.count == 2'd2)
        begin
            q_reg[wr_plus] <= push.r1;
        end
    end

endmodule

// File: rtl/marker_pair_region_scanner.sv
// Marker pair region scanner.
// Input channel s_*: one image byte per beat in s_tdata[7:0]; s_tlast marks the
// last byte of a stream. Output channel m_*: result beats with the kind in
// m_tuser, region start and length in m_tdata, and m_tlast on the terminal
// result of each stream (done, missing end, or markers out of order).
// Configuration channel cfg_*: cfg_index selects begin pattern (0), end
// pattern (1) or marker size (2); other indexes are dropped. cfg_ready is
// always high; write only while the block is idle.
// Throughput: one byte per cycle while s_tready is high, set by the four-cell
// match window and the mode update. Each result is registered in the result
// queue and reaches m_tvalid once earlier results are taken; a byte that both
// closes a region and ends the stream gives two results on consecutive beats.
// A four-entry result queue decouples the sides: s_tready stays high while the
// queue holds two or fewer results, so a stalled receiver backs up the input
// after a few results and nothing is lost.
// Reset clears the window, offsets and mode and restores the default
// patterns and marker size; the result queue comes up empty.
module marker_pair_region_scanner
    import mprs_pkg::*;
#(
    parameter int OFFSET_WIDTH = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // stream_end
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // [31:0] region_start, [63:32] region_length
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast,   // final_res
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    logic [PAT_WIDTH-1:0] begin_reg;
    logic [PAT_WIDTH-1:0] end_reg;
    logic [7:0]           size_reg;
    logic [7:0]           ms_eff;
    logic                 accept;
    logic                 room;
    logic [7:0]           win [WIN_CELLS+1];
    match_t               cell_match [WIN_CELLS];
    match_t               full_match;
    push_t                push;
    result_t              out_res;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_reg <= BEGIN_RESET;
            end_reg   <= END_RESET;
            size_reg  <= SIZE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_BEGIN: begin_reg <= cfg_data;
                CFG_END:   end_reg   <= cfg_data;
                CFG_SIZE:  size_reg  <= cfg_data[7:0];
                default:   ;
            endcase
        end
    end

    assign ms_eff = (size_reg < 8'(PAT_BYTES)) ? 8'(PAT_BYTES) : size_reg;
    assign accept = s_tvalid && s_tready;
    assign s_tready = room;

    // Match window: a row of byte cells, newest byte enters cell 0
    assign win[0] = s_tdata;

    for (genvar k = 0; k < WIN_CELLS; k++)
    begin : g_cell
        mprs_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .shift_en   (accept),
            .clear      (s_tlast),
            .byte_in    (win[k]),
            .begin_byte (begin_reg[8*(k+1) +: 8]),
            .end_byte   (end_reg[8*(k+1) +: 8]),
            .byte_out   (win[k+1]),
            .match      (cell_match[k])
        );
    end

    // Combine cell compares with the incoming byte
    always_comb
    begin
        full_match.hit_begin = (s_tdata == begin_reg[7:0]);
        full_match.hit_end   = (s_tdata == end_reg[7:0]);
        for (int k = 0; k < WIN_CELLS; k++)
        begin
            full_match.hit_begin = full_match.hit_begin && cell_match[k].hit_begin;
            full_match.hit_end   = full_match.hit_end && cell_match[k].hit_end;
        end
    end

    mprs_ctrl #(
        .OFFSET_WIDTH (OFFSET_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .last        (s_tlast),
        .full_match  (full_match),
        .marker_size (ms_eff),
        .push        (push)
    );

    mprs_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = {out_res.length, out_res.start};
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.fin;

endmodule

// File: rtl/mprs_checker.sv
module mprs_checker
    import mprs_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [63:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [39:0] cfg_data
);

    // Hold a stalled result beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Only regions are non-terminal
    a_term: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tuser != KIND_REGION)))
        else $error("terminal flag does not match result kind");

    // Status results carry no offsets
    a_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_REGION |-> m_tdata == 64'd0)
        else $error("status result with nonzero data");

    // Configuration is never back-pressured
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration channel not ready");

endmodule

bind marker_pair_region_scanner mprs_checker u_mprs_checker (.*);

// File: dv/testbench.sv
module testbench;
    import mprs_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 75;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_BEAT = 180;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        SEEK_BEGIN = 2'd0,
        SEEK_END   = 2'd1,
        HALTED     = 2'd2
    } scan_mode_t;

    typedef struct {
        logic [7:0] value;
        logic       last;
    } byte_beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'd0;   // [7:0] data_byte
    logic        s_tlast = 1'b0;   // stream_end
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [63:0] m_tdata;          // [31:0] region_start, [63:32] region_length
    logic [1:0]  m_tuser;          // [1:0] kind
    logic        m_tlast;          // final_res
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = CFG_BEGIN;
    logic [39:0] cfg_data = 40'd0;

    // Scanner state kept by the testbench
    logic [39:0] begin_pat;
    logic [39:0] end_pat;
    logic [7:0]  marker_len;
    logic [31:0] window;
    logic [31:0] next_pos;
    logic [31:0] scan_from;
    logic [31:0] open_at;
    scan_mode_t  mode;
    logic        stray_end;

    result_t    results_due[$];
    byte_beat_t bytes_to_send[$];
    byte_beat_t stream_buf[$];

    int in_beats = 0;
    int issued = 0;
    int out_beats = 0;
    int errors = 0;
    int cycle_count = 0;
    int reg_writes = 0;
    int queued_bytes = 0;
    int tx_idle_pct = 25;
    int rx_idle_pct = 49;
    int hold_left = 0;
    bit hold_done = 1'b0;

    marker_pair_region_scanner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Return stream state to its post-reset values
    function automatic void clear_stream();
        window    = '0;
        next_pos  = '0;
        scan_from = '0;
        open_at   = '0;
        mode      = SEEK_BEGIN;
        stray_end = 1'b0;
    endfunction

    // Emit a region for the open begin marker and resume after the end marker
    function automatic void close_region(input logic [31:0] end_pos, input logic [7:0] ms);
        logic [63:0] delta;
        logic [63:0] span;
        result_t     r;
        delta    = {32'd0, end_pos} - {32'd0, open_at};
        span     = (delta >= {56'd0, ms}) ? delta - {56'd0, ms} : 64'd0;
        r.kind   = KIND_REGION;
        r.start  = open_at + {24'd0, ms};
        r.length = span[31:0];
        r.fin    = 1'b0;
        results_due.insert(results_due.size(), r);
        scan_from = end_pos + {24'd0, ms};
        mode      = SEEK_BEGIN;
        stray_end = 1'b0;
    endfunction

    // Advance the scanner by one byte and queue the results it causes
    function automatic void scan_byte(input logic [7:0] b, input logic last);
        logic [39:0] full;
        logic [7:0]  ms;
        logic        elig;
        logic        hit_b;
        logic        hit_e;
        logic [31:0] at;
        result_t     r;
        ms    = (marker_len < PAT_BYTES) ? 8'(PAT_BYTES) : marker_len;
        full  = {window, b};
        elig  = (next_pos >= scan_from) && (next_pos - scan_from >= 32'(WIN_CELLS));
        hit_b = elig && (full == begin_pat);
        hit_e = elig && (full == end_pat);
        at    = next_pos - 32'(WIN_CELLS);
        window = full[31:0];
        case (mode)
            SEEK_BEGIN:
            begin
                if (hit_b)
                begin
                    if (stray_end)
                        mode = HALTED;
                    else
                    begin
                        open_at = at;
                        if (hit_e)
                            close_region(at, ms);
                        else
                            mode = SEEK_END;
                    end
                end
                else if (hit_e)
                    stray_end = 1'b1;
            end
            SEEK_END:
            begin
                if (hit_e)
                    close_region(at, ms);
            end
            default:
            begin
            end
        endcase
        next_pos = next_pos + 32'd1;
        if (last)
        begin
            case (mode)
                SEEK_BEGIN: r.kind = KIND_DONE;
                SEEK_END:   r.kind = KIND_NO_END;
                default:    r.kind = KIND_ORDER;
            endcase
            r.start  = '0;
            r.length = '0;
            r.fin    = 1'b1;
            results_due.insert(results_due.size(), r);
            clear_stream();
        end
    endfunction

    // Watch both streams: predict on each input beat, check each result beat
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast);
                in_beats++;
            end
            if (m_tvalid && m_tready)
            begin
                got.kind   = m_tuser;
                got.start  = m_tdata[31:0];
                got.length = m_tdata[63:32];
                got.fin    = m_tlast;
                out_beats++;
                if (results_due.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result kind=%0d start=%0d length=%0d last=%0b",
                             $time, got.kind, got.start, got.length, got.fin);
                end
                else
                begin
                    want = results_due.pop_front();
                    if (got.kind !== want.kind || got.start !== want.start ||
                        got.length !== want.length || got.fin !== want.fin)
                    begin
                        errors++;
                        $display("%0t: mismatch expected kind=%0d start=%0d length=%0d last=%0b",
                                 $time, want.kind, want.start, want.length, want.fin);
                        $display("%0t:          actual   kind=%0d start=%0d length=%0d last=%0b",
                                 $time, got.kind, got.start, got.length, got.fin);
                    end
                end
            end
        end
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timed out after %0d cycles with %0d results outstanding",
                     cycle_count, results_due.size());
            $display("FAILURE");
            $finish;
        end
    end

    // Offer the next byte once the current beat is taken
    always @(negedge clk)
    begin
        byte_beat_t nb;
        if (rst_n && !(s_tvalid && issued != in_beats))
        begin
            if (bytes_to_send.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
            begin
                nb = bytes_to_send.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nb.value;
                s_tlast  <= nb.last;
                issued++;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // Drive result ready, with one long hold-off to back up the input
    always @(negedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (!hold_done && in_beats >= HOLD_AT_BEAT)
        begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    function automatic logic [39:0] rand_pattern();
        logic [63:0] r;
        r = {$urandom(), $urandom()};
        return r[39:0];
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [39:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_BEGIN: begin_pat = val;
            CFG_END:   end_pat = val;
            CFG_SIZE:  marker_len = val[7:0];
            default:
            begin
            end
        endcase
        reg_writes++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic void push_byte(input logic [7:0] v);
        byte_beat_t bb;
        bb.value = v;
        bb.last  = 1'b0;
        stream_buf.insert(stream_buf.size(), bb);
    endfunction

    function automatic void push_pattern(input logic [39:0] pat);
        for (int i = PAT_BYTES - 1; i >= 0; i--)
            push_byte(pat[8*i +: 8]);
    endfunction

    function automatic void push_filler(input int n);
        for (int i = 0; i < n; i++)
            push_byte(8'($urandom_range(0, 255)));
    endfunction

    // Mark the last byte and hand the stream to the driver
    function automatic void commit_stream();
        if (stream_buf.size() == 0)
            push_filler(1);
        stream_buf[stream_buf.size() - 1].last = 1'b1;
        foreach (stream_buf[i])
            bytes_to_send.insert(bytes_to_send.size(), stream_buf[i]);
        queued_bytes += stream_buf.size();
        stream_buf.delete();
    endfunction

    // Mostly well-formed marker pairs; some missing ends, reversed pairs and noise
    function automatic void build_stream();
        int ms_eff;
        int gap_max;
        int choice;
        int pairs;
        ms_eff  = (marker_len < PAT_BYTES) ? PAT_BYTES : int'(marker_len);
        gap_max = (ms_eff > 16) ? 20 : ms_eff + 2;
        choice  = $urandom_range(0, 9);
        if (choice <= 6)
        begin
            pairs = $urandom_range(1, 3);
            for (int i = 0; i < pairs; i++)
            begin
                push_filler($urandom_range(0, gap_max));
                push_pattern(begin_pat);
                push_filler($urandom_range(0, gap_max + 4));
                push_pattern(end_pat);
            end
            // leave some streams ending right on the end marker
            if (choice != 6)
                push_filler($urandom_range(0, 3));
        end
        else if (choice == 7)
        begin
            push_filler($urandom_range(0, 6));
            push_pattern(begin_pat);
            push_filler($urandom_range(0, 4));
        end
        else if (choice == 8)
        begin
            push_filler($urandom_range(0, 4));
            push_pattern(end_pat);
            push_filler($urandom_range(0, gap_max));
            push_pattern(begin_pat);
            push_filler($urandom_range(0, 4));
        end
        else
            push_filler($urandom_range(1, 20));
        commit_stream();
    endfunction

    task automatic random_phase();
        int first;
        first = queued_bytes;
        while (queued_bytes - first < PHASE_BYTES)
            build_stream();
    endtask

    // Wait until every byte is taken and every result has come back
    task automatic drain();
        do @(negedge clk);
        while (bytes_to_send.size() != 0 || issued != in_beats || results_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        logic [39:0] pat;
        begin_pat  = BEGIN_RESET;
        end_pat    = END_RESET;
        marker_len = SIZE_RESET;
        clear_stream();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Default markers: region closing on the last byte, reversed pair, missing end
        push_byte(8'h00);
        push_byte(8'hFF);
        push_pattern(begin_pat);
        push_pattern(end_pat);
        commit_stream();
        push_pattern(end_pat);
        push_pattern(begin_pat);
        commit_stream();
        push_pattern(begin_pat);
        commit_stream();
        random_phase();
        drain();

        // Random markers, smallest legal size
        write_reg(CFG_BEGIN, rand_pattern());
        write_reg(CFG_END, rand_pattern());
        write_reg(CFG_SIZE, 40'd5);
        random_phase();
        drain();

        // Swap idling; extreme patterns and a size below the minimum
        tx_idle_pct = 49;
        rx_idle_pct = 25;
        write_reg(CFG_BEGIN, 40'h00_0000_0000);
        write_reg(CFG_END, 40'hFF_FFFF_FFFF);
        write_reg(CFG_SIZE, 40'd0);
        random_phase();
        drain();

        // Identical begin and end markers, largest size, spare index dropped
        pat = rand_pattern();
        write_reg(CFG_BEGIN, pat);
        write_reg(CFG_END, pat);
        write_reg(CFG_SIZE, 40'd255);
        write_reg(CFG_SPARE, rand_pattern());
        push_pattern(pat);
        commit_stream();
        random_phase();
        drain();

        // No idling from here on
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_BEGIN, rand_pattern());
        write_reg(CFG_END, rand_pattern());
        write_reg(CFG_SIZE, 40'd4);
        random_phase();
        drain();

        write_reg(CFG_BEGIN, BEGIN_RESET);
        write_reg(CFG_END, END_RESET);
        write_reg(CFG_SIZE, 40'($urandom_range(5, 16)));
        random_phase();
        drain();

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Scanned %0d bytes and checked %0d result beats over %0d register writes,",
                 in_beats, out_beats, reg_writes);
        $display("with mixed idling and one %0d-cycle receiver hold-off", HOLD_CYCLES);
        if (errors == 0 && results_due.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
